@@ sv/lras_pkg.sv @@
`timescale 1ns / 1ps

package lras_pkg;

    localparam int IDX_W = 11;
    localparam int VAL_W = 64;
    localparam int REQ_W = 3;

    // ancestors held while walking down; a tree over 2047 elements has 12 levels
    localparam int STK_DEPTH = 16;
    localparam int STK_W     = 4;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD  = 3'd0,
        REQ_BUILD = 3'd1,
        REQ_RADD  = 3'd2,
        REQ_QUERY = 3'd3,
        REQ_PADD  = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        PH_NEW,
        PH_LEFT,
        PH_RIGHT
    } t_phase;

endpackage

@@ sv/lazy_range_add_sum_tree_top.sv @@
`timescale 1ns / 1ps
// after reset a clearing pass zeroes the node and source memories; items and configuration
// writes are refused meanwhile; configuration is taken only when idle; a load is written
// from idle, other requests walk the tree one node at a time through registered node
// memories (pushdown and pullup at split nodes); one item at a time, ready again only when idle
module lazy_range_add_sum_tree_top #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [lras_pkg::IDX_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [lras_pkg::REQ_W-1:0]   i_req_type,
    input  logic [lras_pkg::IDX_W-1:0]   i_index_lo,
    input  logic [lras_pkg::IDX_W-1:0]   i_index_hi,
    input  logic signed [lras_pkg::VAL_W-1:0] i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [lras_pkg::VAL_W-1:0] o_range_sum,
    output logic                         o_bad_range
);
    import lras_pkg::*;

    localparam int NODES = 4 * MAX_ELEMENTS;
    localparam int NW    = $clog2(NODES);
    localparam int SW    = $clog2(MAX_ELEMENTS);

    typedef struct packed {
        logic [NW-1:0]    p;
        logic [IDX_W-1:0] l;
        logic [IDX_W-1:0] r;
        t_phase           ph;
    } t_frame;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_ENTER, ST_TERM_RD, ST_TERM_WR, ST_PD_RD, ST_PD_MUL,
        ST_PD_WR, ST_PD_CLR, ST_DESC, ST_POP, ST_RET, ST_PU_RD1, ST_PU_RD2, ST_FIN
    } t_state;

    // memories
    logic [VAL_W-1:0] m_sum  [NODES];
    logic [VAL_W-1:0] m_pend [NODES];
    logic [VAL_W-1:0] m_src  [MAX_ELEMENTS];

    logic             sum_we, sum_re, pend_we, pend_re, src_we, src_re;
    logic [NW-1:0]    sum_wa, sum_ra, pend_wa, pend_ra;
    logic [SW-1:0]    src_wa, src_ra;
    logic [VAL_W-1:0] sum_wd, pend_wd, src_wd;
    logic [VAL_W-1:0] r_sum_q, r_pend_q, r_src_q;

    // control and datapath registers
    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    t_req             r_kind, n_kind;
    logic [IDX_W-1:0] r_lo, n_lo, r_hi, n_hi;
    logic [VAL_W-1:0] r_v, n_v;
    logic [NW-1:0]    r_p, n_p;
    logic [IDX_W-1:0] r_l, n_l, r_r, n_r;
    t_phase           r_ph, n_ph;
    logic [STK_W-1:0] r_sp, n_sp;
    t_frame           r_stk [STK_DEPTH];
    logic             stk_we;
    t_frame           stk_wd;
    logic             r_side, n_side;
    logic [VAL_W-1:0] r_t, n_t, r_prod, n_prod, r_tmp, n_tmp, r_acc, n_acc;
    logic             r_bad, n_bad;
    logic [NW-1:0]    r_clr, n_clr;
    logic             r_out_valid, n_out_valid;
    logic [VAL_W-1:0] r_out_sum, n_out_sum;
    logic             r_out_bad, n_out_bad;

    // node geometry
    logic [IDX_W:0]   lr_sum;
    logic [IDX_W-1:0] mid, cnt_all, cnt_l, cnt_r, mul_b;
    logic             leaf, cov, is_build, is_point, is_query, term, go_l, go_r;
    logic [NW-1:0]    c_left, c_right;
    logic [VAL_W-1:0] mul_a;
    logic [VAL_W+IDX_W-1:0] prod_full;
    logic             range_ok, point_ok, load_ok;
    logic [IDX_W-1:0] cfg_n;

    assign lr_sum   = {1'b0, r_l} + {1'b0, r_r};
    assign mid      = lr_sum[IDX_W:1];
    assign cnt_all  = r_r - r_l + IDX_W'(1);
    assign cnt_l    = mid - r_l + IDX_W'(1);
    assign cnt_r    = r_r - mid;
    assign leaf     = (r_l == r_r);
    assign cov      = (r_lo <= r_l) && (r_r <= r_hi);
    assign is_build = (r_kind == REQ_BUILD);
    assign is_point = (r_kind == REQ_PADD);
    assign is_query = (r_kind == REQ_QUERY);
    assign term     = (is_build || is_point) ? leaf : cov;
    assign go_l     = is_build || (r_lo <= mid);
    assign go_r     = is_build || (r_hi > mid);
    assign c_left   = {r_p[NW-2:0], 1'b0};
    assign c_right  = {r_p[NW-2:0], 1'b1};

    // shared multiplier: span count times add amount
    assign mul_a     = (r_state == ST_PD_MUL) ? r_t : r_v;
    assign mul_b     = (r_state == ST_PD_MUL) ? (r_side ? cnt_r : cnt_l) : cnt_all;
    assign prod_full = mul_a * mul_b;

    assign range_ok = (i_index_lo != '0) && (i_index_lo <= i_index_hi) && (i_index_hi <= r_cnt);
    assign point_ok = (i_index_lo != '0) && (i_index_lo <= r_cnt);
    assign load_ok  = (i_index_lo != '0) && (int'(i_index_lo) <= MAX_ELEMENTS);

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_n = IDX_W'(1);
        end else if (int'(i_cfg_data) > MAX_ELEMENTS) begin
            cfg_n = IDX_W'(MAX_ELEMENTS);
        end else begin
            cfg_n = i_cfg_data;
        end
    end

    // a configuration write takes the idle cycle before any item
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_in_ready  = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_out_valid = r_out_valid;
    assign o_range_sum = r_out_sum;
    assign o_bad_range = r_out_bad;

    always_comb begin
        n_state = r_state;   n_cnt  = r_cnt;   n_kind = r_kind;
        n_lo    = r_lo;      n_hi   = r_hi;    n_v    = r_v;
        n_p     = r_p;       n_l    = r_l;     n_r    = r_r;
        n_ph    = r_ph;      n_sp   = r_sp;    n_side = r_side;
        n_t     = r_t;       n_prod = r_prod;  n_tmp  = r_tmp;
        n_acc   = r_acc;     n_bad  = r_bad;   n_clr  = r_clr;
        n_out_valid = r_out_valid;
        n_out_sum   = r_out_sum;
        n_out_bad   = r_out_bad;
        sum_we = 1'b0;  sum_wa = r_p;  sum_wd = '0;  sum_re = 1'b0;  sum_ra = r_p;
        pend_we = 1'b0; pend_wa = r_p; pend_wd = '0; pend_re = 1'b0; pend_ra = r_p;
        src_we = 1'b0;  src_wa = SW'(i_index_lo - IDX_W'(1)); src_wd = i_value;
        src_re = 1'b0;  src_ra = SW'(r_l - IDX_W'(1));
        stk_we = 1'b0;
        stk_wd = '{p: r_p, l: r_l, r: r_r, ph: PH_LEFT};

        if (i_cfg_valid && o_cfg_ready) begin
            n_cnt = cfg_n;
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                sum_we  = 1'b1;
                sum_wa  = r_clr;
                pend_we = 1'b1;
                pend_wa = r_clr;
                src_we  = (int'(r_clr) < MAX_ELEMENTS);
                src_wa  = SW'(r_clr);
                src_wd  = '0;
                n_clr   = r_clr + NW'(1);
                if (r_clr == NW'(NODES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_kind = t_req'(i_req_type);
                    n_lo   = i_index_lo;
                    n_hi   = i_index_hi;
                    n_v    = i_value;
                    n_p    = NW'(1);
                    n_l    = IDX_W'(1);
                    n_r    = r_cnt;
                    n_ph   = PH_NEW;
                    n_sp   = '0;
                    n_acc  = '0;
                    n_bad  = 1'b0;
                    unique case (t_req'(i_req_type))
                        REQ_LOAD: begin
                            src_we = load_ok;
                        end
                        REQ_BUILD: begin
                            n_state = ST_ENTER;
                        end
                        REQ_RADD: begin
                            if (range_ok) begin
                                n_state = ST_ENTER;
                            end
                        end
                        REQ_QUERY: begin
                            n_bad   = !range_ok;
                            n_state = range_ok ? ST_ENTER : ST_FIN;
                        end
                        REQ_PADD: begin
                            n_hi = i_index_lo;
                            if (point_ok) begin
                                n_state = ST_ENTER;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ENTER: begin
                if (is_build) begin
                    pend_we = 1'b1;
                    if (leaf) begin
                        src_re  = 1'b1;
                        n_state = ST_TERM_RD;
                    end else begin
                        n_state = ST_DESC;
                    end
                end else if (term) begin
                    sum_re  = 1'b1;
                    pend_re = 1'b1;
                    n_state = ST_TERM_RD;
                end else begin
                    pend_re = 1'b1;
                    n_state = ST_PD_RD;
                end
            end
            ST_TERM_RD: begin
                if (is_build) begin
                    sum_we  = 1'b1;
                    sum_wd  = r_src_q;
                    n_state = ST_POP;
                end else if (is_query) begin
                    n_acc   = r_acc + r_sum_q;
                    n_state = ST_POP;
                end else begin
                    n_prod  = prod_full[VAL_W-1:0];
                    n_state = ST_TERM_WR;
                end
            end
            ST_TERM_WR: begin
                sum_we  = 1'b1;
                sum_wd  = r_sum_q + r_prod;
                pend_we = !is_point;
                pend_wd = r_pend_q + r_v;
                n_state = ST_POP;
            end
            ST_PD_RD: begin
                n_t = r_pend_q;
                if (r_pend_q == '0) begin
                    n_state = ST_DESC;
                end else begin
                    n_side  = 1'b0;
                    sum_re  = 1'b1;
                    sum_ra  = c_left;
                    pend_re = 1'b1;
                    pend_ra = c_left;
                    n_state = ST_PD_MUL;
                end
            end
            ST_PD_MUL: begin
                n_prod  = prod_full[VAL_W-1:0];
                n_state = ST_PD_WR;
            end
            ST_PD_WR: begin
                sum_we  = 1'b1;
                sum_wa  = r_side ? c_right : c_left;
                sum_wd  = r_sum_q + r_prod;
                pend_we = 1'b1;
                pend_wa = r_side ? c_right : c_left;
                pend_wd = r_pend_q + r_t;
                if (!r_side) begin
                    n_side  = 1'b1;
                    sum_re  = 1'b1;
                    sum_ra  = c_right;
                    pend_re = 1'b1;
                    pend_ra = c_right;
                    n_state = ST_PD_MUL;
                end else begin
                    n_state = ST_PD_CLR;
                end
            end
            ST_PD_CLR: begin
                pend_we = 1'b1;
                n_state = ST_DESC;
            end
            ST_DESC: begin
                stk_we  = 1'b1;
                n_sp    = r_sp + STK_W'(1);
                n_ph    = PH_NEW;
                n_state = ST_ENTER;
                if (go_l) begin
                    stk_wd.ph = PH_LEFT;
                    n_p = c_left;
                    n_r = mid;
                end else begin
                    stk_wd.ph = PH_RIGHT;
                    n_p = c_right;
                    n_l = mid + IDX_W'(1);
                end
            end
            ST_POP: begin
                if (r_sp == '0) begin
                    n_state = ST_FIN;
                end else begin
                    n_p     = r_stk[r_sp - STK_W'(1)].p;
                    n_l     = r_stk[r_sp - STK_W'(1)].l;
                    n_r     = r_stk[r_sp - STK_W'(1)].r;
                    n_ph    = r_stk[r_sp - STK_W'(1)].ph;
                    n_sp    = r_sp - STK_W'(1);
                    n_state = ST_RET;
                end
            end
            ST_RET: begin
                if ((r_ph == PH_LEFT) && go_r) begin
                    // left subtree done, now the right one
                    stk_we    = 1'b1;
                    stk_wd.ph = PH_RIGHT;
                    n_sp      = r_sp + STK_W'(1);
                    n_p       = c_right;
                    n_l       = mid + IDX_W'(1);
                    n_ph      = PH_NEW;
                    n_state   = ST_ENTER;
                end else begin
                    sum_re  = 1'b1;
                    sum_ra  = c_left;
                    n_state = ST_PU_RD1;
                end
            end
            ST_PU_RD1: begin
                n_tmp   = r_sum_q;
                sum_re  = 1'b1;
                sum_ra  = c_right;
                n_state = ST_PU_RD2;
            end
            ST_PU_RD2: begin
                sum_we  = 1'b1;
                sum_wd  = r_tmp + r_sum_q;
                n_state = ST_POP;
            end
            ST_FIN: begin
                if (!is_query) begin
                    n_state = ST_IDLE;
                end else if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_sum   = r_bad ? '0 : r_acc;
                    n_out_bad   = r_bad;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (sum_we) begin
            m_sum[sum_wa] <= sum_wd;
        end
        if (sum_re) begin
            r_sum_q <= m_sum[sum_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pend_we) begin
            m_pend[pend_wa] <= pend_wd;
        end
        if (pend_re) begin
            r_pend_q <= m_pend[pend_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (src_we) begin
            m_src[src_wa] <= src_wd;
        end
        if (src_re) begin
            r_src_q <= m_src[src_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= IDX_W'(1);
            r_sp        <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_kind      <= REQ_LOAD;
            r_ph        <= PH_NEW;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_sp        <= n_sp;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_kind      <= n_kind;
            r_ph        <= n_ph;
        end
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_v       <= n_v;
        r_p       <= n_p;
        r_l       <= n_l;
        r_r       <= n_r;
        r_side    <= n_side;
        r_t       <= n_t;
        r_prod    <= n_prod;
        r_tmp     <= n_tmp;
        r_acc     <= n_acc;
        r_bad     <= n_bad;
        r_out_sum <= n_out_sum;
        r_out_bad <= n_out_bad;
        if (stk_we) begin
            r_stk[r_sp] <= stk_wd;
        end
    end

    a_idle_empty_stack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_sp == '0))
        else $error("walk ended with ancestors left on the stack");

    a_bad_sum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_range) |-> (o_range_sum == '0))
        else $error("flagged query carries a nonzero sum");

    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_req_type == REQ_LOAD)) |=> (r_state == ST_IDLE))
        else $error("load item did not complete in one cycle");

    a_result_only_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(o_out_valid) && o_out_valid) |-> ($past(r_state) == ST_FIN && is_query))
        else $error("result raised outside a finished query");

endmodule

@@ test/tb_lazy_range_add_sum_tree_top.sv @@
`timescale 1ns / 1ps

module tb_lazy_range_add_sum_tree_top;
    import lras_pkg::*;

    localparam int MAXN  = 1024;
    localparam int NODES = 4 * MAXN;
    localparam logic [REQ_W-1:0] REQ_UNUSED5 = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNUSED7 = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [IDX_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic [REQ_W-1:0] i_req_type = '0;
    logic [IDX_W-1:0] i_index_lo = '0;
    logic [IDX_W-1:0] i_index_hi = '0;
    logic signed [VAL_W-1:0] i_value = '0;
    logic i_out_ready = 1'b0;
    logic o_cfg_ready, o_in_ready, o_out_valid, o_bad_range;
    logic signed [VAL_W-1:0] o_range_sum;

    always #1 i_clk = ~i_clk;

    lazy_range_add_sum_tree_top #(.MAX_ELEMENTS(MAXN)) dut (.*);

    typedef struct packed {
        logic [63:0] sum;
        logic        bad;
    } t_answer;

    t_answer answers_due[$];
    int errors = 0;
    int sums_checked = 0;
    int items_sent = 0;
    bit calm = 0;
    int hold_cycles = 0;

    // tree shadow
    logic [63:0] tree_sum [NODES];
    logic [63:0] tree_lazy [NODES];
    logic [63:0] src_val [MAXN];
    int unsigned cur_n = 1;

    function automatic void tr_pull(int unsigned p);
        if (2 * p + 1 >= NODES) return;
        tree_sum[p] = tree_sum[2*p] + tree_sum[2*p+1];
    endfunction

    function automatic void tr_push(int unsigned p, int unsigned l, int unsigned r);
        logic [63:0] t;
        int unsigned m;
        if (2 * p + 1 >= NODES) return;
        t = tree_lazy[p];
        if (t == 0) return;
        m = (l + r) >> 1;
        tree_sum[2*p]   += 64'(m - l + 1) * t;
        tree_sum[2*p+1] += 64'(r - m) * t;
        tree_lazy[2*p]   += t;
        tree_lazy[2*p+1] += t;
        tree_lazy[p] = '0;
    endfunction

    function automatic void tr_build(int unsigned p, int unsigned l, int unsigned r);
        int unsigned m;
        if (p >= NODES) return;
        tree_lazy[p] = '0;
        if (l == r) begin
            tree_sum[p] = (l >= 1 && l <= MAXN) ? src_val[l-1] : '0;
            return;
        end
        m = (l + r) >> 1;
        tr_build(2*p, l, m);
        tr_build(2*p+1, m + 1, r);
        tr_pull(p);
    endfunction

    function automatic void tr_point(int unsigned p, int unsigned l, int unsigned r,
                                     int unsigned pos, logic [63:0] v);
        int unsigned m;
        if (p >= NODES) return;
        if (l == r) begin
            tree_sum[p] += v;
            return;
        end
        tr_push(p, l, r);
        m = (l + r) >> 1;
        if (pos <= m) tr_point(2*p, l, m, pos, v);
        else tr_point(2*p+1, m + 1, r, pos, v);
        tr_pull(p);
    endfunction

    function automatic void tr_radd(int unsigned p, int unsigned l, int unsigned r,
                                    int unsigned lo, int unsigned hi, logic [63:0] v);
        int unsigned m;
        if (p >= NODES) return;
        if (lo <= l && r <= hi) begin
            tree_sum[p] += 64'(r - l + 1) * v;
            tree_lazy[p] += v;
            return;
        end
        tr_push(p, l, r);
        m = (l + r) >> 1;
        if (lo <= m) tr_radd(2*p, l, m, lo, hi, v);
        if (hi > m) tr_radd(2*p+1, m + 1, r, lo, hi, v);
        tr_pull(p);
    endfunction

    function automatic logic [63:0] tr_query(int unsigned p, int unsigned l, int unsigned r,
                                             int unsigned lo, int unsigned hi);
        int unsigned m;
        logic [63:0] acc;
        acc = '0;
        if (p >= NODES) return '0;
        if (lo <= l && r <= hi) return tree_sum[p];
        tr_push(p, l, r);
        m = (l + r) >> 1;
        if (lo <= m) acc += tr_query(2*p, l, m, lo, hi);
        if (hi > m) acc += tr_query(2*p+1, m + 1, r, lo, hi);
        tr_pull(p);
        return acc;
    endfunction

    // updates the shadow; returns 1 and the answer for a query
    function automatic bit apply_request(logic [2:0] kind, int unsigned lo, int unsigned hi,
                                         logic [63:0] v, output t_answer ans);
        bit ok;
        ok = lo >= 1 && lo <= hi && hi <= cur_n;
        ans = '0;
        case (kind)
            REQ_LOAD: begin
                if (lo >= 1 && lo <= MAXN) src_val[lo-1] = v;
            end
            REQ_BUILD: tr_build(1, 1, cur_n);
            REQ_RADD: begin
                if (ok) tr_radd(1, 1, cur_n, lo, hi, v);
            end
            REQ_QUERY: begin
                if (ok) ans.sum = tr_query(1, 1, cur_n, lo, hi);
                else ans.bad = 1'b1;
                return 1;
            end
            REQ_PADD: begin
                if (lo >= 1 && lo <= cur_n) tr_point(1, 1, cur_n, lo, v);
            end
            default: ;
        endcase
        return 0;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    // result side: random stalls, optional long hold-off
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(99) >= 38);
        end
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (answers_due.size() == 0) begin
                report("unexpected sum", o_range_sum, '0);
            end else begin
                want = answers_due.pop_front();
                sums_checked++;
                if (o_range_sum !== want.sum) report("range_sum", o_range_sum, want.sum);
                if (o_bad_range !== want.bad) report("bad_range", 64'(o_bad_range), 64'(want.bad));
            end
        end
    end

    task automatic send(logic [2:0] kind, logic [10:0] lo, logic [10:0] hi, logic [63:0] v,
                        bit typed = 0, t_answer typed_ans = '0);
        int gap;
        t_answer ans;
        gap = (calm || $urandom_range(99) >= 38) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= kind;
        i_index_lo <= lo;
        i_index_hi <= hi;
        i_value <= v;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (apply_request(kind, lo, hi, v, ans)) answers_due.push_back(typed ? typed_ans : ans);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        // a build gives no result and may still be walking the tree
        repeat (16 * cur_n + 800) @(posedge i_clk);
    endtask

    task automatic set_count(logic [10:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_n = (d == 0) ? 1 : (d > MAXN ? MAXN : d);
    endtask

    function automatic logic [63:0] rand_value();
        case ($urandom_range(3))
            0: return 64'($urandom_range(200)) - 64'd100;
            1: return {1'b0, {63{1'b1}}} ^ 64'($urandom_range(1));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_item();
        int unsigned lo, hi, pick;
        logic [2:0] kind;
        pick = $urandom_range(99);
        lo = $urandom_range(1, cur_n);
        hi = $urandom_range(lo, cur_n);
        if (pick < 10) begin
            // noise: arbitrary indexes and types, mostly bad ranges
            kind = 3'($urandom_range(7));
            send(kind, 11'($urandom), 11'($urandom), rand_value());
        end else begin
            if (pick < 22) kind = REQ_PADD;
            else if (pick < 50) kind = REQ_RADD;
            else if (pick < 53) kind = REQ_LOAD;
            else if (pick < 54) kind = REQ_BUILD;
            else kind = REQ_QUERY;
            send(kind, 11'(lo), 11'(hi), rand_value());
        end
    endtask

    typedef struct {
        logic [2:0]  kind;
        logic [10:0] lo;
        logic [10:0] hi;
        logic [63:0] v;
        bit          typed;
        logic [63:0] sum;
        bit          bad;
    } t_row;

    t_row directed [] = '{
        '{REQ_QUERY, 11'd1, 11'd1, 64'd0, 1, 64'd0, 0},
        '{REQ_QUERY, 11'd0, 11'd0, 64'd0, 1, 64'd0, 1},
        '{REQ_QUERY, 11'd2, 11'd2, 64'd0, 1, 64'd0, 1},
        '{REQ_QUERY, 11'h7ff, 11'h7ff, 64'd0, 1, 64'd0, 1},
        '{REQ_LOAD, 11'd0, 11'd0, 64'd5, 0, 64'd0, 0},
        '{REQ_LOAD, 11'd1, 11'd0, 64'h7fff_ffff_ffff_ffff, 0, 64'd0, 0},
        '{REQ_LOAD, 11'd1024, 11'd0, 64'h8000_0000_0000_0000, 0, 64'd0, 0},
        '{REQ_LOAD, 11'd2047, 11'd0, 64'hffff_ffff_ffff_ffff, 0, 64'd0, 0},
        '{REQ_QUERY, 11'd1, 11'd1, 64'd0, 1, 64'd0, 0},
        '{REQ_BUILD, 11'd0, 11'd0, 64'd0, 0, 64'd0, 0},
        '{REQ_QUERY, 11'd1, 11'd1, 64'd0, 1, 64'h7fff_ffff_ffff_ffff, 0},
        '{REQ_RADD, 11'd1, 11'd1, 64'd1, 0, 64'd0, 0},
        '{REQ_QUERY, 11'd1, 11'd1, 64'd0, 1, 64'h8000_0000_0000_0000, 0},
        '{REQ_PADD, 11'd1, 11'd0, 64'hffff_ffff_ffff_ffff, 0, 64'd0, 0},
        '{REQ_PADD, 11'd2, 11'd0, 64'd9, 0, 64'd0, 0},
        '{REQ_RADD, 11'd2, 11'd1, 64'd9, 0, 64'd0, 0},
        '{REQ_RADD, 11'd0, 11'd1, 64'd9, 0, 64'd0, 0},
        '{REQ_UNUSED5, 11'd1, 11'd1, 64'd9, 0, 64'd0, 0},
        '{3'd6, 11'd1, 11'd1, 64'd9, 0, 64'd0, 0},
        '{REQ_UNUSED7, 11'd1, 11'd1, 64'd9, 0, 64'd0, 0},
        '{REQ_QUERY, 11'd1, 11'd0, 64'd0, 1, 64'd0, 1},
        '{REQ_QUERY, 11'd1, 11'd1, 64'd0, 1, 64'h7fff_ffff_ffff_ffff, 0}
    };

    // element counts per phase: clamped extremes, tiny, odd and full sizes
    int phase_counts [] = '{0, 2047, 2, 5, 33, 1024, 1, 64, 1023, 7, 1024, 128};

    initial begin
        t_answer ta;
        int per_phase;
        foreach (tree_sum[i]) begin
            tree_sum[i] = '0;
            tree_lazy[i] = '0;
        end
        foreach (src_val[i]) src_val[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            ta.sum = directed[i].sum;
            ta.bad = directed[i].bad;
            send(directed[i].kind, directed[i].lo, directed[i].hi, directed[i].v,
                 directed[i].typed, ta);
        end
        drain();

        foreach (phase_counts[ph]) begin
            set_count(11'(phase_counts[ph]));
            calm = (ph == 3);
            per_phase = (cur_n >= 512) ? 90 : 130;
            // load the sources, then build; one phase keeps the stale tree instead
            for (int k = 0; k < ((cur_n > 40) ? 40 : cur_n); k++)
                send(REQ_LOAD, 11'($urandom_range(1, cur_n)), 11'($urandom), rand_value());
            if (ph != 4) send(REQ_BUILD, 11'($urandom), 11'($urandom), 64'($urandom));
            if (ph == 2) hold_cycles = 3000;
            for (int k = 0; k < per_phase; k++) begin
                random_item();
                if (ph == 7 && k == per_phase / 2) begin
                    i_in_valid <= 1'b0;
                    while (answers_due.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        $display("sent %0d items over %0d element counts, %0d sums checked",
                 items_sent, phase_counts.size(), sums_checked);
        if (errors == 0) begin
            $display("PASS lazy_range_add_sum_tree_top");
        end else begin
            $display("FAIL lazy_range_add_sum_tree_top");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("FAIL lazy_range_add_sum_tree_top");
        $finish;
    end

endmodule

@@ lazy_range_add_sum_tree_top.f @@
sv/lras_pkg.sv
sv/lazy_range_add_sum_tree_top.sv
test/tb_lazy_range_add_sum_tree_top.sv
